// ===== rtl/core/mtf_pkg.sv =====
// Shared types, constants and the CRC byte function of the multi-target frame builder.
`default_nettype none

package mtf_pkg;

  localparam int unsigned MAX_CHANNELS = 24;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned CNT_LIMIT    = (MAX_CHANNELS > 31) ? 31 :
                                         ((MAX_CHANNELS < 1) ? 1 : MAX_CHANNELS);
  localparam int unsigned TGT_W        = 14;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned ADDR_W       = 4;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic [BYTE_W-1:0] FRAME_START = 8'h9F;
  localparam logic [BYTE_W-1:0] POLY_RESET  = 8'h91;

  typedef enum logic [1:0] {
    REG_COUNT  = 2'd0,
    REG_FIRST  = 2'd1,
    REG_CRC_EN = 2'd2,
    REG_POLY   = 2'd3
  } reg_idx_e;

  // One classified target as it travels from the front to the back.
  typedef struct packed {
    logic [TGT_W-1:0] target;
    logic             hdr;
    logic             last;
    logic             crc_en;
  } cmd_t;

  // Configuration seen by the byte sequencer.
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [BYTE_W-1:0] first_ch;
    logic [BYTE_W-1:0] poly;
  } cfg_t;

  // Right-shifting byte-wise CRC update.
  function automatic logic [BYTE_W-1:0] crc_byte(input logic [BYTE_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data,
                                                 input logic [BYTE_W-1:0] poly);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = c ^ poly;
      end
      c = c >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mtf_if.sv =====
// Valid/ready channel interfaces for target beats and frame byte beats.
`default_nettype none

interface mtf_in_if
  import mtf_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [TGT_W-1:0] target;

  modport source (output valid, output target, input ready);
  modport sink   (input valid, input target, output ready);
endinterface

interface mtf_out_if
  import mtf_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              frame_end;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_end,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/servo_multi_target_frame_crc7.sv =====
// Top level of the servo multi-target command frame builder with optional CRC byte.
`default_nettype none

// Each target beat on in_if becomes part of a set-multiple-targets frame on out_if,
// one byte per beat. The first target of a frame is preceded by the header 0x9F, the
// channel count (0 taken as 1, values above MAX_CHANNELS taken as MAX_CHANNELS) and
// the first channel number. Every target then sends its bits 6..0 and 13..7, each in
// the low seven bits of a byte. When crc_enable is set, the last target of the frame is
// followed by one CRC byte over all frame bytes, using the polynomial register
// (right-shifting, byte-wise). run_last marks the last byte caused by a target,
// frame_end the final byte of the frame. The byte sequencer emits one byte per cycle
// unless the queue is empty or the output stalls, so a target takes two bytes, plus
// three header bytes on the first target of a frame and one CRC byte on the last.
// Target beats are classified and queued in a four-entry command queue, so input
// beats are taken while earlier targets are still being serialized or the output waits.
// Registers (APB, byte address 4*i): 0 channel_count, 1 first_channel, 2 crc_enable,
// 3 crc_polynomial (reset 0x91). Write them only while no frame bytes are pending.
module servo_multi_target_frame_crc7
  import mtf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  mtf_in_if.sink                 in_if,
  mtf_out_if.source              out_if,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output      logic [DATA_W-1:0] prdata,
  output      logic              pready
);

  // Configuration registers.
  logic [CNT_W-1:0]  count_q;
  logic [BYTE_W-1:0] first_q;
  logic              crc_en_q;
  logic [BYTE_W-1:0] poly_q;
  logic              cfg_wr;
  reg_idx_e          reg_idx;
  logic [CNT_W-1:0]  count_eff;

  // Front-to-back command path.
  logic push, full, pop, cmd_valid;
  cmd_t cmd_w, cmd_r;
  cfg_t cfg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= CNT_W'(1);
      first_q  <= '0;
      crc_en_q <= 1'b0;
      poly_q   <= POLY_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_COUNT:  count_q  <= pwdata[CNT_W-1:0];
        REG_FIRST:  first_q  <= pwdata[BYTE_W-1:0];
        REG_CRC_EN: crc_en_q <= pwdata[0];
        REG_POLY:   poly_q   <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the stored register values.
  always_comb begin
    unique case (reg_idx)
      REG_COUNT:  prdata = {{(DATA_W-CNT_W){1'b0}}, count_q};
      REG_FIRST:  prdata = {{(DATA_W-BYTE_W){1'b0}}, first_q};
      REG_CRC_EN: prdata = {{(DATA_W-1){1'b0}}, crc_en_q};
      REG_POLY:   prdata = {{(DATA_W-BYTE_W){1'b0}}, poly_q};
      default:    prdata = '0;
    endcase
  end

  // Clamp the count into 1..MAX_CHANNELS; it sets both the frame length and header byte.
  assign count_eff = (count_q == '0)               ? CNT_W'(1) :
                     (count_q > CNT_W'(CNT_LIMIT)) ? CNT_W'(CNT_LIMIT) : count_q;

  always_comb begin
    cfg.count    = count_eff;
    cfg.first_ch = first_q;
    cfg.poly     = poly_q;
  end

  mtf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .count_i  (count_eff),
    .crc_en_i (crc_en_q),
    .full_i   (full),
    .push_o   (push),
    .cmd_o    (cmd_w)
  );

  mtf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_w),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .rdata_o (cmd_r)
  );

  mtf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_r),
    .pop_o       (pop),
    .cfg_i       (cfg),
    .out_if      (out_if)
  );

endmodule

`default_nettype wire

// ===== rtl/core/mtf_front.sv =====
// Front end: accepts target beats, tracks the frame position and classifies each target.
`default_nettype none

module mtf_front
  import mtf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  mtf_in_if.sink                in_if,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire logic             crc_en_i,
  input  wire logic             full_i,
  output      logic             push_o,
  output      cmd_t             cmd_o
);

  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W:0]   idx_inc;
  logic             last;

  assign in_if.ready = !full_i;
  assign push_o      = in_if.valid && !full_i;

  assign idx_inc = {1'b0, idx_q} + {{CNT_W{1'b0}}, 1'b1};
  assign last    = idx_inc >= {1'b0, count_i};
  assign idx_d   = last ? '0 : idx_inc[CNT_W-1:0];

  always_comb begin
    cmd_o.target = in_if.target;
    cmd_o.hdr    = (idx_q == '0);
    cmd_o.last   = last;
    cmd_o.crc_en = crc_en_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (push_o) begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mtf_fifo.sv =====
// Short command queue between the front end and the byte sequencer.
`default_nettype none

module mtf_fifo
  import mtf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t wdata_i,
  output      logic full_o,
  input  wire logic pop_i,
  output      logic valid_o,
  output      cmd_t rdata_o
);

  cmd_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               do_pop;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + FIFO_AW'(1);
      end
      cnt_q <= cnt_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(do_pop);
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("command pushed into a full queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue fill count out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/mtf_back.sv =====
// Back end: walks each command through its frame bytes, keeps the CRC, registers the output.
`default_nettype none

module mtf_back
  import mtf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output      logic pop_o,
  input  wire cfg_t cfg_i,
  mtf_out_if.source out_if
);

  typedef enum logic [2:0] {
    PH_H0  = 3'd0,
    PH_H1  = 3'd1,
    PH_H2  = 3'd2,
    PH_LO  = 3'd3,
    PH_HI  = 3'd4,
    PH_CRC = 3'd5
  } ph_e;

  ph_e               ph_q, ph_d, cur_ph;
  logic [BYTE_W-1:0] crc_q, byte_d;
  logic              out_valid_q, run_last_q, frame_end_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              emit, last_byte, with_crc;

  assign with_crc = cmd_i.last && cmd_i.crc_en;
  assign cur_ph   = (ph_q == PH_H0 && !cmd_i.hdr) ? PH_LO : ph_q;
  assign emit     = cmd_valid_i && (!out_valid_q || out_if.ready);
  assign pop_o    = emit && last_byte;

  always_comb begin
    unique case (cur_ph)
      PH_H0: begin
        byte_d = FRAME_START; ph_d = PH_H1; last_byte = 1'b0;
      end
      PH_H1: begin
        byte_d = {{(BYTE_W-CNT_W){1'b0}}, cfg_i.count}; ph_d = PH_H2; last_byte = 1'b0;
      end
      PH_H2: begin
        byte_d = cfg_i.first_ch; ph_d = PH_LO; last_byte = 1'b0;
      end
      PH_LO: begin
        byte_d = {1'b0, cmd_i.target[6:0]}; ph_d = PH_HI; last_byte = 1'b0;
      end
      PH_HI: begin
        byte_d    = {1'b0, cmd_i.target[13:7]};
        ph_d      = with_crc ? PH_CRC : PH_H0;
        last_byte = !with_crc;
      end
      PH_CRC: begin
        byte_d = crc_q; ph_d = PH_H0; last_byte = 1'b1;
      end
      default: begin
        byte_d = '0; ph_d = PH_H0; last_byte = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_H0;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      run_last_q  <= 1'b0;
      frame_end_q <= 1'b0;
    end else if (emit) begin
      ph_q        <= ph_d;
      out_valid_q <= 1'b1;
      out_byte_q  <= byte_d;
      run_last_q  <= last_byte;
      frame_end_q <= last_byte && cmd_i.last;
      if (last_byte && cmd_i.last) begin
        crc_q <= '0;
      end else if (cur_ph != PH_CRC) begin
        crc_q <= crc_byte(crc_q, byte_d, cfg_i.poly);
      end
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.out_byte  = out_byte_q;
  assign out_if.run_last  = run_last_q;
  assign out_if.frame_end = frame_end_q;

`ifndef SYNTH
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && frame_end_q |-> run_last_q) else $error("frame end without run end");
  a_crc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && last_byte && cmd_i.last |=> crc_q == '0) else $error("CRC not cleared");
  a_pop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> ph_q == PH_H0) else $error("sequencer not rewound after command");
`endif

endmodule

`default_nettype wire
